/* rtl/core/isds_pkg.sv */
// Shared types, constants and helper functions for the iterated SHA-256 stretch block.
// Depends on nothing; the stretch top level, the schedule unit and the round unit import it.
package isds_pkg;

    localparam int ISDS_WORD_W = 32;
    localparam int ISDS_PASS_W = 33;
    localparam int ISDS_RND_W  = 6;

    typedef logic [ISDS_WORD_W-1:0] isds_word_t;
    typedef logic [7:0][ISDS_WORD_W-1:0] isds_block_t;

    // Control from the sequencer to the schedule and round units.
    typedef struct packed {
        logic load;
        logic step;
    } isds_ctl_t;

    // Sequencer states, one-hot.
    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_ROUND = 3'b010,
        ST_FINAL = 3'b100
    } isds_state_t;

    // Register index of the configuration port.
    localparam logic ISDS_REG_ITER = 1'b0;

    localparam logic [31:0] ISDS_ITER_RESET = 32'd2048;
    localparam logic [31:0] ISDS_PAD_WORD   = 32'h8000_0000;
    localparam logic [31:0] ISDS_LEN_WORD   = 32'd256;
    localparam logic [ISDS_RND_W-1:0] ISDS_LAST_RND = 6'd63;

    // Standard initial hash values, word 0 in the lowest slot.
    localparam isds_block_t ISDS_IV = {
        32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
        32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
    };

    function automatic isds_word_t isds_ror(input isds_word_t x, input int n);
        isds_ror = (x >> n) | (x << (ISDS_WORD_W - n));
    endfunction

    function automatic isds_word_t isds_ssig0(input isds_word_t x);
        isds_ssig0 = isds_ror(x, 7) ^ isds_ror(x, 18) ^ (x >> 3);
    endfunction

    function automatic isds_word_t isds_ssig1(input isds_word_t x);
        isds_ssig1 = isds_ror(x, 17) ^ isds_ror(x, 19) ^ (x >> 10);
    endfunction

    function automatic isds_word_t isds_bsig0(input isds_word_t x);
        isds_bsig0 = isds_ror(x, 2) ^ isds_ror(x, 13) ^ isds_ror(x, 22);
    endfunction

    function automatic isds_word_t isds_bsig1(input isds_word_t x);
        isds_bsig1 = isds_ror(x, 6) ^ isds_ror(x, 11) ^ isds_ror(x, 25);
    endfunction

    // Round constant table.
    function automatic isds_word_t isds_k(input logic [ISDS_RND_W-1:0] idx);
        unique case (idx)
            6'd0:  isds_k = 32'h428a2f98;  6'd1:  isds_k = 32'h71374491;
            6'd2:  isds_k = 32'hb5c0fbcf;  6'd3:  isds_k = 32'he9b5dba5;
            6'd4:  isds_k = 32'h3956c25b;  6'd5:  isds_k = 32'h59f111f1;
            6'd6:  isds_k = 32'h923f82a4;  6'd7:  isds_k = 32'hab1c5ed5;
            6'd8:  isds_k = 32'hd807aa98;  6'd9:  isds_k = 32'h12835b01;
            6'd10: isds_k = 32'h243185be;  6'd11: isds_k = 32'h550c7dc3;
            6'd12: isds_k = 32'h72be5d74;  6'd13: isds_k = 32'h80deb1fe;
            6'd14: isds_k = 32'h9bdc06a7;  6'd15: isds_k = 32'hc19bf174;
            6'd16: isds_k = 32'he49b69c1;  6'd17: isds_k = 32'hefbe4786;
            6'd18: isds_k = 32'h0fc19dc6;  6'd19: isds_k = 32'h240ca1cc;
            6'd20: isds_k = 32'h2de92c6f;  6'd21: isds_k = 32'h4a7484aa;
            6'd22: isds_k = 32'h5cb0a9dc;  6'd23: isds_k = 32'h76f988da;
            6'd24: isds_k = 32'h983e5152;  6'd25: isds_k = 32'ha831c66d;
            6'd26: isds_k = 32'hb00327c8;  6'd27: isds_k = 32'hbf597fc7;
            6'd28: isds_k = 32'hc6e00bf3;  6'd29: isds_k = 32'hd5a79147;
            6'd30: isds_k = 32'h06ca6351;  6'd31: isds_k = 32'h14292967;
            6'd32: isds_k = 32'h27b70a85;  6'd33: isds_k = 32'h2e1b2138;
            6'd34: isds_k = 32'h4d2c6dfc;  6'd35: isds_k = 32'h53380d13;
            6'd36: isds_k = 32'h650a7354;  6'd37: isds_k = 32'h766a0abb;
            6'd38: isds_k = 32'h81c2c92e;  6'd39: isds_k = 32'h92722c85;
            6'd40: isds_k = 32'ha2bfe8a1;  6'd41: isds_k = 32'ha81a664b;
            6'd42: isds_k = 32'hc24b8b70;  6'd43: isds_k = 32'hc76c51a3;
            6'd44: isds_k = 32'hd192e819;  6'd45: isds_k = 32'hd6990624;
            6'd46: isds_k = 32'hf40e3585;  6'd47: isds_k = 32'h106aa070;
            6'd48: isds_k = 32'h19a4c116;  6'd49: isds_k = 32'h1e376c08;
            6'd50: isds_k = 32'h2748774c;  6'd51: isds_k = 32'h34b0bcb5;
            6'd52: isds_k = 32'h391c0cb3;  6'd53: isds_k = 32'h4ed8aa4a;
            6'd54: isds_k = 32'h5b9cca4f;  6'd55: isds_k = 32'h682e6ff3;
            6'd56: isds_k = 32'h748f82ee;  6'd57: isds_k = 32'h78a5636f;
            6'd58: isds_k = 32'h84c87814;  6'd59: isds_k = 32'h8cc70208;
            6'd60: isds_k = 32'h90befffa;  6'd61: isds_k = 32'ha4506ceb;
            6'd62: isds_k = 32'hbef9a3f7;  6'd63: isds_k = 32'hc67178f2;
            default: isds_k = 32'h0;
        endcase
    endfunction

endpackage

/* rtl/core/iterated_sha256_digest_stretch.sv */
// Iterated SHA-256 stretch: sequencer, configuration port and output register.
// Each of the N + 1 passes, N being the extra-pass count, runs the rounds in the shared
// round unit and then a finalize state.
// The block takes no new item until it is done with the last; s_tready is high only while idle.
// A waiting result does not block it in idle, but holds the finalize state until the output is free.
// Reset (aresetn low, synchronous) returns to idle, drops m_tvalid, sets the extra-pass count to 2048.
module iterated_sha256_digest_stretch (
    input  logic         aclk,
    input  logic         aresetn,
    // Configuration port
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    // Input items
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [255:0] s_tdata,   // in_word_0 .. in_word_7, 32 bits each, from the lowest bit up
    // Result items
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [255:0] m_tdata    // out_word_0 .. out_word_7, 32 bits each, from the lowest bit up
);
    import isds_pkg::*;

    isds_state_t               state_reg, state_next;
    logic [ISDS_RND_W-1:0]     rnd_reg, rnd_next;
    logic [ISDS_PASS_W-1:0]    passes_reg, passes_next;
    logic [31:0]               iter_reg, iter_next;
    logic                      m_valid_reg, m_valid_next;
    isds_block_t               out_reg, out_next;

    isds_ctl_t                 ctl;
    isds_block_t               msg;
    isds_block_t               vars;
    isds_block_t               sums;
    isds_word_t                w;
    logic                      s_acc;
    logic                      cfg_wr;
    logic                      more;
    logic                      out_free;

    // Configuration register write and read back.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == ISDS_REG_ITER);
    assign prdata = (paddr[2] == ISDS_REG_ITER) ? iter_reg : 32'h0;
    assign iter_next = cfg_wr ? pwdata : iter_reg;

    // Handshake and pass bookkeeping.
    assign s_tready = (state_reg == ST_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign more     = (passes_reg != ISDS_PASS_W'(1));
    assign out_free = !m_valid_reg || m_tready;

    // Chaining value after a pass.
    always_comb begin
        for (int i = 0; i < 8; i++) begin
            sums[i] = ISDS_IV[i] + vars[i];
        end
    end

    // The first pass hashes the input item, later passes hash the previous digest.
    assign msg      = (state_reg == ST_IDLE) ? isds_block_t'(s_tdata) : sums;
    assign ctl.load = s_acc || ((state_reg == ST_FINAL) && more);
    assign ctl.step = (state_reg == ST_ROUND);

    // Sequencer.
    always_comb begin
        state_next   = state_reg;
        rnd_next     = rnd_reg;
        passes_next  = passes_reg;
        out_next     = out_reg;
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    passes_next = {1'b0, iter_reg} + ISDS_PASS_W'(1);
                    rnd_next    = '0;
                    state_next  = ST_ROUND;
                end
            end
            ST_ROUND: begin
                rnd_next = rnd_reg + ISDS_RND_W'(1);
                if (rnd_reg == ISDS_LAST_RND) begin
                    state_next = ST_FINAL;
                end
            end
            ST_FINAL: begin
                if (more) begin
                    passes_next = passes_reg - ISDS_PASS_W'(1);
                    rnd_next    = '0;
                    state_next  = ST_ROUND;
                end else if (out_free) begin
                    passes_next  = '0;
                    out_next     = sums;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            rnd_reg     <= '0;
            passes_reg  <= '0;
            iter_reg    <= ISDS_ITER_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            rnd_reg     <= rnd_next;
            passes_reg  <= passes_next;
            iter_reg    <= iter_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Result payload.
    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = out_reg;

    isds_sched u_sched (
        .aclk (aclk),
        .ctl  (ctl),
        .msg  (msg),
        .w    (w)
    );

    isds_round u_round (
        .aclk (aclk),
        .ctl  (ctl),
        .w    (w),
        .k    (isds_k(rnd_reg)),
        .vars (vars)
    );

endmodule

/* rtl/core/isds_sched.sv */
// Message schedule window: a 16-word shift line that yields one schedule word per round.
// Depends on isds_pkg.
module isds_sched (
    input  logic                    aclk,
    input  isds_pkg::isds_ctl_t     ctl,
    input  isds_pkg::isds_block_t   msg,
    output isds_pkg::isds_word_t    w
);
    import isds_pkg::*;

    logic [15:0][ISDS_WORD_W-1:0] win_reg;
    logic [15:0][ISDS_WORD_W-1:0] win_next;
    isds_word_t                   w_new;

    // Next schedule word, sixteen rounds ahead of the one in use now.
    assign w_new = isds_ssig1(win_reg[14]) + win_reg[9] + isds_ssig0(win_reg[1]) + win_reg[0];

    // Load a padded single block, or shift the window by one word.
    always_comb begin
        win_next = win_reg;
        if (ctl.load) begin
            win_next[7:0]  = msg;
            win_next[8]    = ISDS_PAD_WORD;
            win_next[14:9] = '0;
            win_next[15]   = ISDS_LEN_WORD;
        end else if (ctl.step) begin
            win_next[14:0] = win_reg[15:1];
            win_next[15]   = w_new;
        end
    end

    always_ff @(posedge aclk) begin
        win_reg <= win_next;
    end

    assign w = win_reg[0];

endmodule

/* rtl/core/isds_round.sv */
// Shared SHA-256 round unit: working variables a..h and one compression round per cycle while stepping.
// Depends on isds_pkg.
module isds_round (
    input  logic                    aclk,
    input  isds_pkg::isds_ctl_t     ctl,
    input  isds_pkg::isds_word_t    w,
    input  isds_pkg::isds_word_t    k,
    output isds_pkg::isds_block_t   vars
);
    import isds_pkg::*;

    isds_block_t vars_reg;
    isds_block_t vars_next;
    isds_word_t  t1;
    isds_word_t  t2;

    // Round sums; slot 0 is a, slot 7 is h.
    assign t1 = vars_reg[7] + isds_bsig1(vars_reg[4])
              + (vars_reg[6] ^ (vars_reg[4] & (vars_reg[5] ^ vars_reg[6]))) + k + w;
    assign t2 = isds_bsig0(vars_reg[0])
              + ((vars_reg[0] & vars_reg[1]) | (vars_reg[2] & (vars_reg[0] | vars_reg[1])));

    // Start from the initial values or advance one round.
    always_comb begin
        vars_next = vars_reg;
        if (ctl.load) begin
            vars_next = ISDS_IV;
        end else if (ctl.step) begin
            vars_next[7] = vars_reg[6];
            vars_next[6] = vars_reg[5];
            vars_next[5] = vars_reg[4];
            vars_next[4] = vars_reg[3] + t1;
            vars_next[3] = vars_reg[2];
            vars_next[2] = vars_reg[1];
            vars_next[1] = vars_reg[0];
            vars_next[0] = t1 + t2;
        end
    end

    always_ff @(posedge aclk) begin
        vars_reg <= vars_next;
    end

    assign vars = vars_reg;

endmodule

/* rtl/core/isds_checker.sv */
// Port-level checks for the iterated SHA-256 stretch block, bound to its top level.
// Depends only on the top level's ports.
module isds_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [255:0] m_tdata
);

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // The block is busy right after it takes an item.
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken again right after an accept");

    // No result can appear in the cycle after an item is taken.
    a_no_early: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !$rose(m_tvalid))
        else $error("result appeared too early");

    // Reset leaves the block idle with no result pending.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> s_tready && !m_tvalid)
        else $error("block not idle after reset");

endmodule

bind iterated_sha256_digest_stretch isds_checker u_isds_checker (.*);
